[src/cor_pkg.sv]
// ----------------------------------------------------------------------------
// cor_pkg
// Shared types and constants of the circle outline rasterizer.
// ----------------------------------------------------------------------------
package cor_pkg;

  localparam int COLOR_BITS = 8;
  localparam int NUM_PIXELS = 8;
  localparam int PHASE_BITS = $clog2(NUM_PIXELS);

  localparam logic ACTION_START = 1'b0;
  localparam logic ACTION_STEP  = 1'b1;

  typedef logic [PHASE_BITS-1:0] phase_t;

  localparam phase_t PHASE_LAST = phase_t'(NUM_PIXELS - 1);

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic [COLOR_BITS-1:0] alpha;
  } colour_t;

endpackage

[src/cor_if.sv]
// ----------------------------------------------------------------------------
// cor_if
// Valid/ready channels of the circle outline rasterizer: circle commands in,
// pixels out.
// ----------------------------------------------------------------------------
interface cor_in_if import cor_pkg::*; #(
  parameter int COORD_BITS = 12
) ();
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic        [COORD_BITS-2:0]  circle_radius;
  logic        [COLOR_BITS-1:0]  red_in;
  logic        [COLOR_BITS-1:0]  green_in;
  logic        [COLOR_BITS-1:0]  blue_in;
  logic        [COLOR_BITS-1:0]  alpha_in;

  modport source (output valid, action, center_x, center_y, circle_radius,
                  red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, action, center_x, center_y, circle_radius,
                  red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface cor_out_if import cor_pkg::*; #(
  parameter int COORD_BITS = 12
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS:0]    pixel_x;
  logic signed [COORD_BITS:0]    pixel_y;
  logic        [COLOR_BITS-1:0]  red_out;
  logic        [COLOR_BITS-1:0]  green_out;
  logic        [COLOR_BITS-1:0]  blue_out;
  logic        [COLOR_BITS-1:0]  alpha_out;
  logic                          last_of_step;
  logic                          circle_done;

  modport source (output valid, pixel_x, pixel_y, red_out, green_out, blue_out,
                  alpha_out, last_of_step, circle_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, red_out, green_out, blue_out,
                  alpha_out, last_of_step, circle_done, output ready);
endinterface

[src/circle_outline_rasterizer_unit.sv]
// ----------------------------------------------------------------------------
// circle_outline_rasterizer_unit
// Andres circle outline generator: start transactions latch a circle, step
// transactions advance the error term and emit eight symmetric pixels.
// ----------------------------------------------------------------------------
//  channel   dir  transaction
//  in_ch     in   start (latch circle) or step (advance one step)
//  out_ch    out  one pixel with colour, last_of_step, circle_done
//
//  A step is evaluated in the cycle it is accepted; its eight pixels then
//  leave from the pixel buffer one per cycle while out_ch.ready is high.
//  in_ch.ready is high while the pixel buffer is empty or its eighth pixel
//  is being taken, so steps run back to back.
//  Start transactions and idle steps emit nothing.
//  rst_n is synchronous: idle, no circle active, buffer empty.
// ----------------------------------------------------------------------------
module circle_outline_rasterizer_unit import cor_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,
  cor_in_if.sink    in_ch,
  cor_out_if.source out_ch
);

  localparam int CB = COORD_BITS;
  localparam int EB = CB + 2;
  localparam int WB = CB + 3;

  // circle state
  logic signed [CB-1:0] x_r, x_nxt, cx_r, cy_r;
  logic signed [CB-1:0] y_r, y_nxt;
  logic signed [EB-1:0] err_r, err_nxt;
  logic        [CB-2:0] radius_r;
  colour_t              colour_r;
  logic                 active_r, active_nxt;

  // pixel buffer
  logic signed [CB-1:0] sx_r, sy_r, scx_r, scy_r;
  colour_t              scol_r;
  logic                 sdone_r;
  logic                 busy_r, busy_nxt;
  phase_t               phase_r, phase_nxt;

  logic free, acc, start_acc, step_acc, out_fire, emit_last;

  logic signed [WB-1:0] xe, ye, ee, re, x2, ry2, err1, err2, err3;
  logic signed [CB-1:0] x_inc, y_dec;
  logic                 done_c;

  logic signed [CB:0]   xp, yp, dx, dy, cxp, cyp;

  assign emit_last = busy_r && (phase_r == PHASE_LAST);
  assign out_fire  = busy_r && out_ch.ready;
  assign free      = !busy_r || (emit_last && out_ch.ready);
  assign in_ch.ready = free;
  assign acc       = in_ch.valid && free;
  assign start_acc = acc && (in_ch.action == ACTION_START);
  assign step_acc  = acc && (in_ch.action == ACTION_STEP) && active_r;

  // error-term step
  always_comb begin
    xe   = WB'(x_r);
    ye   = WB'(y_r);
    ee   = WB'(err_r);
    re   = $signed({{(WB-CB+1){1'b0}}, radius_r});
    x2   = xe <<< 1;
    ry2  = (re - ye) <<< 1;
    err1 = ee - x2 - WB'(1);
    err2 = ee + (ye <<< 1) - WB'(1);
    err3 = ee + ((ye - xe - WB'(1)) <<< 1);
    x_inc = x_r + CB'(1);
    y_dec = y_r - CB'(1);
    if (ee >= x2) begin
      err_nxt = err1[EB-1:0];
      x_nxt   = x_inc;
      y_nxt   = y_r;
    end else if (ee < ry2) begin
      err_nxt = err2[EB-1:0];
      x_nxt   = x_r;
      y_nxt   = y_dec;
    end else begin
      err_nxt = err3[EB-1:0];
      x_nxt   = x_inc;
      y_nxt   = y_dec;
    end
    done_c     = y_nxt < x_nxt;
    active_nxt = !done_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      y_r      <= '0;
      err_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      radius_r <= '0;
      colour_r <= '0;
      active_r <= 1'b0;
    end else if (start_acc) begin
      x_r      <= '0;
      y_r      <= $signed({1'b0, in_ch.circle_radius});
      err_r    <= $signed({{(EB-CB+1){1'b0}}, in_ch.circle_radius}) - EB'(1);
      cx_r     <= in_ch.center_x;
      cy_r     <= in_ch.center_y;
      radius_r <= in_ch.circle_radius;
      colour_r <= '{red: in_ch.red_in, green: in_ch.green_in,
                    blue: in_ch.blue_in, alpha: in_ch.alpha_in};
      active_r <= 1'b1;
    end else if (step_acc) begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      err_r    <= err_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_acc) begin
      sx_r    <= x_r;
      sy_r    <= y_r;
      scx_r   <= cx_r;
      scy_r   <= cy_r;
      scol_r  <= colour_r;
      sdone_r <= done_c;
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    if (out_fire) begin
      phase_nxt = phase_r + phase_t'(1);
      if (emit_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (step_acc) begin
      busy_nxt  = 1'b1;
      phase_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
    end
  end

  // octant select
  always_comb begin
    xp  = (CB+1)'(sx_r);
    yp  = (CB+1)'(sy_r);
    cxp = (CB+1)'(scx_r);
    cyp = (CB+1)'(scy_r);
    case (phase_r)
      phase_t'(0): begin dx =  xp; dy =  yp; end
      phase_t'(1): begin dx =  xp; dy = -yp; end
      phase_t'(2): begin dx =  yp; dy = -xp; end
      phase_t'(3): begin dx =  yp; dy =  xp; end
      phase_t'(4): begin dx = -xp; dy =  yp; end
      phase_t'(5): begin dx = -xp; dy = -yp; end
      phase_t'(6): begin dx = -yp; dy =  xp; end
      default:     begin dx = -yp; dy = -xp; end
    endcase
  end

  assign out_ch.valid        = busy_r;
  assign out_ch.pixel_x      = cxp + dx;
  assign out_ch.pixel_y      = cyp + dy;
  assign out_ch.red_out      = scol_r.red;
  assign out_ch.green_out    = scol_r.green;
  assign out_ch.blue_out     = scol_r.blue;
  assign out_ch.alpha_out    = scol_r.alpha;
  assign out_ch.last_of_step = phase_r == PHASE_LAST;
  assign out_ch.circle_done  = (phase_r == PHASE_LAST) && sdone_r;

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for circle_outline_rasterizer_unit. A directed table
// covers idle steps, radius-zero circles at the corners of the coordinate
// range, the largest radius and a start that abandons a running circle.
// Random well-formed circles follow: a start and then steps until done, with
// some cut short by a new start and some stray steps while idle. Every pixel
// transaction is compared field by field against an in-bench Andres circle
// tracker. Both channels idle at random, and the pixel side holds off once
// for a long stretch so the block backs up into its command channel.
// ----------------------------------------------------------------------------
module testbench import cor_pkg::*;;

  localparam int COORD_BITS = 12;
  localparam int NUM_ITEMS  = 350;
  localparam int HOLD_LEN   = 300;

  typedef enum {ROW_MODEL, ROW_SILENT, ROW_CENTER} row_kind_t;

  typedef struct packed {
    logic                         action;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic        [COORD_BITS-2:0] rad;
    colour_t                      col;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_BITS:0] px;
    logic signed [COORD_BITS:0] py;
    colour_t                    col;
    logic                       last;
    logic                       fin;
  } pixel_t;

  typedef struct {
    row_kind_t kind;
    logic      action;
    int        cx;
    int        cy;
    int        rad;
    colour_t   col;
    int        ex;
    int        ey;
    colour_t   ecol;
  } row_t;

  logic clk;
  logic rst_n;

  cor_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
  cor_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

  circle_outline_rasterizer_unit #(.COORD_BITS(COORD_BITS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // circle tracker state
  int      pen_x, pen_y, err_acc;
  int      ctr_x, ctr_y, radius_q;
  colour_t ink;
  bit      drawing;

  pixel_t    pixel_q[$];
  row_kind_t cur_kind;
  int        cur_ex, cur_ey;
  colour_t   cur_ecol;

  int n_fail, n_items, n_starts, n_steps, n_pixels, n_circles;
  bit quiet, hold_req;

  row_t dir_rows [20] = '{
    '{ROW_SILENT, ACTION_STEP,      0,     0,    0, 32'h00000000, 0, 0, 32'h0},
    '{ROW_SILENT, ACTION_START,     0,     0,    0, 32'hFFFFFFFF, 0, 0, 32'h0},
    '{ROW_CENTER, ACTION_STEP,      0,     0,    0, 32'h00000000, 0, 0, 32'hFFFFFFFF},
    '{ROW_SILENT, ACTION_STEP,   2047,  2047, 2047, 32'hFFFFFFFF, 0, 0, 32'h0},
    '{ROW_SILENT, ACTION_START,  2047, -2048,    0, 32'h00000000, 0, 0, 32'h0},
    '{ROW_CENTER, ACTION_STEP,      0,     0,    0, 32'h00000000,
      2047, -2048, 32'h00000000},
    '{ROW_SILENT, ACTION_START, -2048,  2047,    0, 32'hA55AC33C, 0, 0, 32'h0},
    '{ROW_CENTER, ACTION_STEP,      0,     0,    0, 32'hFFFFFFFF,
      -2048, 2047, 32'hA55AC33C},
    '{ROW_SILENT, ACTION_START,  2047,  2047, 2047, 32'hFFFFFFFF, 0, 0, 32'h0},
    '{ROW_MODEL,  ACTION_STEP,      0,     0,    0, 32'h00000000, 0, 0, 32'h0},
    '{ROW_MODEL,  ACTION_STEP,   2047,  2047, 2047, 32'hFFFFFFFF, 0, 0, 32'h0},
    '{ROW_MODEL,  ACTION_STEP,      0,     0,    0, 32'h00000000, 0, 0, 32'h0},
    '{ROW_SILENT, ACTION_START, -2048, -2048, 2047, 32'h5AA53CC3, 0, 0, 32'h0},
    '{ROW_MODEL,  ACTION_STEP,      0,     0,    0, 32'h00000000, 0, 0, 32'h0},
    '{ROW_MODEL,  ACTION_STEP,      0,     0,    0, 32'h00000000, 0, 0, 32'h0},
    '{ROW_SILENT, ACTION_START,   100,  -100,    3, 32'h12345678, 0, 0, 32'h0},
    '{ROW_MODEL,  ACTION_STEP,      0,     0,    0, 32'h00000000, 0, 0, 32'h0},
    '{ROW_MODEL,  ACTION_STEP,      0,     0,    0, 32'h00000000, 0, 0, 32'h0},
    '{ROW_MODEL,  ACTION_STEP,      0,     0,    0, 32'h00000000, 0, 0, 32'h0},
    '{ROW_MODEL,  ACTION_STEP,      0,     0,    0, 32'h00000000, 0, 0, 32'h0}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("[circle_outline_rasterizer_unit] ERROR");
    $finish;
  end

  function automatic void emit(ref pixel_t l[$], input int px, input int py,
                               input colour_t c, input bit last, input bit fin);
    pixel_t p;
    p.px   = (COORD_BITS+1)'(px);
    p.py   = (COORD_BITS+1)'(py);
    p.col  = c;
    p.last = last;
    p.fin  = fin;
    l.push_back(p);
  endfunction

  // Andres step: latch on start, else emit the octant pixels and move on
  function automatic void advance_circle(input cmd_t c, ref pixel_t l[$]);
    int x, y;
    bit fin;
    l = {};
    if (c.action == ACTION_START) begin
      ctr_x    = int'(c.cx);
      ctr_y    = int'(c.cy);
      radius_q = int'(c.rad);
      ink      = c.col;
      pen_x    = 0;
      pen_y    = radius_q;
      err_acc  = radius_q - 1;
      drawing  = 1'b1;
      return;
    end
    if (!drawing) return;
    x = pen_x;
    y = pen_y;
    if (err_acc >= 2 * x) begin
      err_acc = err_acc - 2 * x - 1;
      pen_x   = x + 1;
    end else if (err_acc < 2 * (radius_q - y)) begin
      err_acc = err_acc + 2 * y - 1;
      pen_y   = y - 1;
    end else begin
      err_acc = err_acc + 2 * (y - x - 1);
      pen_y   = y - 1;
      pen_x   = x + 1;
    end
    fin = (pen_y < pen_x);
    if (fin) drawing = 1'b0;
    emit(l, ctr_x + x, ctr_y + y, ink, 1'b0, 1'b0);
    emit(l, ctr_x + x, ctr_y - y, ink, 1'b0, 1'b0);
    emit(l, ctr_x + y, ctr_y - x, ink, 1'b0, 1'b0);
    emit(l, ctr_x + y, ctr_y + x, ink, 1'b0, 1'b0);
    emit(l, ctr_x - x, ctr_y + y, ink, 1'b0, 1'b0);
    emit(l, ctr_x - x, ctr_y - y, ink, 1'b0, 1'b0);
    emit(l, ctr_x - y, ctr_y + x, ink, 1'b0, 1'b0);
    emit(l, ctr_x - y, ctr_y - x, ink, 1'b1, fin);
  endfunction

  // accepted command transactions
  always @(posedge clk) begin
    cmd_t   c;
    pixel_t res[$];
    if (rst_n && in_ch.valid && in_ch.ready) begin
      c = '{in_ch.action, in_ch.center_x, in_ch.center_y, in_ch.circle_radius,
            '{in_ch.red_in, in_ch.green_in, in_ch.blue_in, in_ch.alpha_in}};
      advance_circle(c, res);
      if (c.action == ACTION_START) n_starts++;
      else if (res.size() != 0) n_steps++;
      case (cur_kind)
        ROW_SILENT: res = {};
        ROW_CENTER: begin
          res = {};
          for (int k = 0; k < NUM_PIXELS; k++)
            emit(res, cur_ex, cur_ey, cur_ecol, k == NUM_PIXELS - 1,
                 k == NUM_PIXELS - 1);
        end
        default: ;
      endcase
      foreach (res[k]) pixel_q.push_back(res[k]);
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      n_fail++;
      $display("%0t: pixel %0d %s mismatch, expected %0d, got %0d",
               $time, n_pixels, name, exp_v, act_v);
    end
  endtask

  // accepted pixel transactions
  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pixel_q.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected pixel, expected none, got (%0d,%0d)",
                 $time, out_ch.pixel_x, out_ch.pixel_y);
      end else begin
        e = pixel_q.pop_front();
        check_field("pixel_x",      int'(e.px),        int'(out_ch.pixel_x));
        check_field("pixel_y",      int'(e.py),        int'(out_ch.pixel_y));
        check_field("red_out",      int'(e.col.red),   int'(out_ch.red_out));
        check_field("green_out",    int'(e.col.green), int'(out_ch.green_out));
        check_field("blue_out",     int'(e.col.blue),  int'(out_ch.blue_out));
        check_field("alpha_out",    int'(e.col.alpha), int'(out_ch.alpha_out));
        check_field("last_of_step", int'(e.last),      int'(out_ch.last_of_step));
        check_field("circle_done",  int'(e.fin),       int'(out_ch.circle_done));
      end
      n_pixels++;
      if (out_ch.circle_done) n_circles++;
    end
  end

  // pixel sink: random stalls plus one long hold-off
  initial begin
    int  hold_left;
    bit  hold_used;
    hold_left     = 0;
    hold_used     = 1'b0;
    out_ch.ready  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold_left = HOLD_LEN;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = !(!quiet && $urandom_range(0, 99) < 6);
      end
    end
  end

  task automatic send(input cmd_t c, input row_kind_t k = ROW_MODEL,
                      input int ex = 0, input int ey = 0,
                      input colour_t ecol = '0);
    while (!quiet && $urandom_range(0, 99) < 6) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    if (c.action == ACTION_START || drawing) n_items++;
    if (n_items == 150) hold_req = 1'b1;
    quiet = (n_items >= 220 && n_items < 280);
    cur_kind            = k;
    cur_ex              = ex;
    cur_ey              = ey;
    cur_ecol            = ecol;
    in_ch.action        = c.action;
    in_ch.center_x      = c.cx;
    in_ch.center_y      = c.cy;
    in_ch.circle_radius = c.rad;
    in_ch.red_in        = c.col.red;
    in_ch.green_in      = c.col.green;
    in_ch.blue_in       = c.col.blue;
    in_ch.alpha_in      = c.col.alpha;
    in_ch.valid         = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic cmd_t rand_cmd(input logic action);
    cmd_t c;
    c.action = action;
    c.cx     = COORD_BITS'($urandom);
    c.cy     = COORD_BITS'($urandom);
    c.rad    = (COORD_BITS-1)'($urandom);
    c.col    = colour_t'($urandom);
    return c;
  endfunction

  task automatic run_random();
    cmd_t c;
    int   steps, cap, pick;
    bit   big;
    while (n_items < NUM_ITEMS) begin
      c    = rand_cmd(ACTION_START);
      pick = $urandom_range(0, 99);
      big  = (pick < 4);
      if (big) c.rad = (COORD_BITS-1)'($urandom_range(0, 2047));
      else if (pick < 25) c.rad = (COORD_BITS-1)'($urandom_range(25, 60));
      else c.rad = (COORD_BITS-1)'($urandom_range(0, 24));
      send(c);
      cap   = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 6) : (big ? 40 : 1000);
      steps = 0;
      while (drawing && steps < cap) begin
        send(rand_cmd(ACTION_STEP));
        steps++;
      end
      if ($urandom_range(0, 99) < 10)
        repeat ($urandom_range(1, 2)) send(rand_cmd(ACTION_STEP));
    end
  endtask

  initial begin
    cmd_t c;
    n_fail    = 0;
    n_items   = 0;
    n_starts  = 0;
    n_steps   = 0;
    n_pixels  = 0;
    n_circles = 0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    drawing   = 1'b0;
    pen_x     = 0;
    pen_y     = 0;
    err_acc   = 0;
    ctr_x     = 0;
    ctr_y     = 0;
    radius_q  = 0;
    ink       = '0;
    cur_kind  = ROW_MODEL;
    cur_ex    = 0;
    cur_ey    = 0;
    cur_ecol  = '0;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACTION_STEP;
    in_ch.center_x      = '0;
    in_ch.center_y      = '0;
    in_ch.circle_radius = '0;
    in_ch.red_in        = '0;
    in_ch.green_in      = '0;
    in_ch.blue_in       = '0;
    in_ch.alpha_in      = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      c.action = dir_rows[i].action;
      c.cx     = COORD_BITS'(dir_rows[i].cx);
      c.cy     = COORD_BITS'(dir_rows[i].cy);
      c.rad    = (COORD_BITS-1)'(dir_rows[i].rad);
      c.col    = dir_rows[i].col;
      send(c, dir_rows[i].kind, dir_rows[i].ex, dir_rows[i].ey, dir_rows[i].ecol);
    end
    run_random();
    in_ch.valid = 1'b0;

    while (pixel_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Covered %0d commands: %0d starts, %0d drawing steps, %0d pixels,",
             n_items, n_starts, n_steps, n_pixels);
    $display("%0d circles run to completion, one long pixel-side hold-off.", n_circles);
    if (n_fail == 0) begin
      $display("[circle_outline_rasterizer_unit] OK");
    end else begin
      $display("[circle_outline_rasterizer_unit] ERROR");
    end
    $finish;
  end

endmodule
